@@ sv/qpp_pkg.sv @@
// Shared constants, types and helpers for the quadrant profile check.
// No dependencies; every other file of the block but qpp_ram uses this package.
package qpp_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BRIGHT_THR   = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
  localparam logic [PIX_W-1:0]  THR_RESET    = PIX_W'(30);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic pix_rd;
    logic pix_wr;
    logic walk_start;
    logic walk_rd;
    logic div_load;
    logic div_step;
    logic acc;
    logic mul;
    logic cmp;
    logic out_load;
  } qpp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic frame_end;
    logic div_last;
    logic entry_last;
    logic profile_last;
    logic out_busy;
  } qpp_sts_t;

  // floor(s/3) for s <= 765 as a multiply by 683/2048
  function automatic logic [PIX_W-1:0] qpp_gray(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    logic [9:0]  s;
    logic [19:0] p;
    s = {2'b00, r} + {2'b00, g} + {2'b00, b};
    p = {10'd0, s} * 20'd683;
    return p[18:11];
  endfunction

endpackage

@@ sv/qpp_if.sv @@
// Valid/ready channel interfaces for pixel beats and result beats.
// Depends on qpp_pkg for field widths.
interface qpp_pixel_if;
  logic                    valid;
  logic                    ready;
  logic [qpp_pkg::PIX_W-1:0] red;
  logic [qpp_pkg::PIX_W-1:0] green;
  logic [qpp_pkg::PIX_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface qpp_result_if;
  logic                    valid;
  logic                    ready;
  logic                    frame_good;
  logic [7:0]              negative_mask;
  logic [qpp_pkg::PIX_W-1:0] peak_value;
  modport source (output valid, frame_good, negative_mask, peak_value, input ready);
  modport sink   (input valid, frame_good, negative_mask, peak_value, output ready);
endinterface

@@ sv/quadrant_profile_palm_check.sv @@
// Quadrant profile check. Each pixel beat is read, then its column sum is
// written back; a new pixel is taken only after that write-back. After the
// last pixel of a frame the walk reads each profile entry, loads the divider,
// runs 8 divider steps and accumulates, then multiplies and compares once per
// profile; pixels stall then. Async active-low reset restores 640x480,
// threshold 30, empty frame; sum memories need no clearing.
module quadrant_profile_palm_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qpp_pixel_if.sink                     pix_in,
  qpp_result_if.source                  res_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qpp_pkg::ADDR_W-1:0]    paddr,
  input  logic [qpp_pkg::DATA_W-1:0]    pwdata,
  output logic [qpp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import qpp_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q;
  logic [PIX_W-1:0]  thr_q;
  logic              wr_en, cfg_clear;
  logic [1:0]        reg_idx;
  qpp_cmd_t          cmd;
  qpp_sts_t          sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  // A size write abandons the frame in progress
  assign cfg_clear = wr_en && ((reg_idx == REG_FRAME_WIDTH) || (reg_idx == REG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      thr_q    <= THR_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
        REG_BRIGHT_THR:   thr_q    <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = {{(DATA_W-SIZE_W){1'b0}}, width_q};
      REG_FRAME_HEIGHT: prdata = {{(DATA_W-SIZE_W){1'b0}}, height_q};
      REG_BRIGHT_THR:   prdata = {{(DATA_W-PIX_W){1'b0}}, thr_q};
      default:          prdata = '0;
    endcase
  end

  // Sequencer: takes a pixel beat only when idle
  qpp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (pix_in.valid),
    .in_ready_o (pix_in.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath holds the result register, so the next frame starts while
  // a result beat waits downstream
  qpp_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_clear_i     (cfg_clear),
    .width_i         (width_q),
    .height_i        (height_q),
    .thr_i           (thr_q),
    .red_i           (pix_in.red),
    .green_i         (pix_in.green),
    .blue_i          (pix_in.blue),
    .out_ready_i     (res_out.ready),
    .out_valid_o     (res_out.valid),
    .frame_good_o    (res_out.frame_good),
    .negative_mask_o (res_out.negative_mask),
    .peak_value_o    (res_out.peak_value)
  );
endmodule

@@ sv/qpp_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module qpp_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

@@ sv/qpp_ctrl.sv @@
// Sequencer for pixel accumulation, the profile walk and result hand-off.
// Depends on qpp_pkg for the command and status structs.
module qpp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qpp_pkg::qpp_sts_t sts_i,
  output qpp_pkg::qpp_cmd_t cmd_o
);
  import qpp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_RD, S_LD, S_DIV, S_ACC, S_MUL, S_CMP, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.pix_rd = 1'b1;
          state_d      = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.pix_wr = 1'b1;
        if (sts_i.frame_end) begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = S_LD;
      end
      S_LD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.entry_last ? S_MUL : S_RD;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.profile_last ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ sv/qpp_datapath.sv @@
// Sum memories, position counters, iterative divider and profile tests.
// Depends on qpp_pkg and qpp_ram.
module qpp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qpp_pkg::qpp_cmd_t           cmd_i,
  output qpp_pkg::qpp_sts_t           sts_o,
  input  logic                        cfg_clear_i,
  input  logic [qpp_pkg::SIZE_W-1:0]  width_i,
  input  logic [qpp_pkg::SIZE_W-1:0]  height_i,
  input  logic [qpp_pkg::PIX_W-1:0]   thr_i,
  input  logic [qpp_pkg::PIX_W-1:0]   red_i,
  input  logic [qpp_pkg::PIX_W-1:0]   green_i,
  input  logic [qpp_pkg::PIX_W-1:0]   blue_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        frame_good_o,
  output logic [7:0]                  negative_mask_o,
  output logic [qpp_pkg::PIX_W-1:0]   peak_value_o
);
  import qpp_pkg::*;

  typedef enum logic [1:0] {SEL_TOP, SEL_BOT, SEL_LEFT, SEL_RIGHT} sel_e;

  localparam int unsigned PROD_W = XW + SUM_W;

  // Clamped geometry
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [XW-1:0]     wh, wr;
  logic [YW-1:0]     hh, hr;

  always_comb begin
    if (width_i < SIZE_W'(2))              w_eff = SIZE_W'(2);
    else if (width_i > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
    else                                   w_eff = width_i;
    if (height_i < SIZE_W'(2))               h_eff = SIZE_W'(2);
    else if (height_i > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
    else                                     h_eff = height_i;
  end

  logic [SIZE_W-1:0] wr_full, hr_full;
  assign wh      = w_eff[XW:1];
  assign hh      = h_eff[YW:1];
  assign wr_full = w_eff - {1'b0, wh};
  assign hr_full = h_eff - {1'b0, hh};
  assign wr      = wr_full[XW-1:0];
  assign hr      = hr_full[YW-1:0];

  // Pixel side
  logic [XW-1:0]    x_q;
  logic [YW-1:0]    y_q;
  logic [SUM_W-1:0] lacc_q, racc_q, lacc_new, racc_new;
  logic [PIX_W-1:0] gray_q;
  logic [SUM_W-1:0] gray_ext, col_rd, col_new;
  logic             row_end, top_half, in_left, first_row;

  assign gray_ext  = {{(SUM_W-PIX_W){1'b0}}, gray_q};
  assign row_end   = ({1'b0, x_q} == w_eff - SIZE_W'(1));
  assign sts_o.frame_end = row_end && ({1'b0, y_q} == h_eff - SIZE_W'(1));
  assign top_half  = (y_q < hh);
  assign in_left   = (x_q < wh);
  assign first_row = (y_q == '0) || (y_q == hh);
  assign lacc_new  = in_left ? lacc_q + gray_ext : lacc_q;
  assign racc_new  = in_left ? racc_q : racc_q + gray_ext;

  // Walk side
  logic [2:0]       p_q;
  logic [XW-1:0]    j_q;
  logic [XW-1:0]    first, n, dv, half, walk_addr;
  logic             rev, is_head;
  sel_e             sel;

  always_comb begin
    unique case (p_q)
      3'd0: begin sel = SEL_TOP;   first = '0;            n = wh;       rev = 1'b1; dv = hh; end
      3'd1: begin sel = SEL_LEFT;  first = '0;            n = hh;       rev = 1'b1; dv = wh; end
      3'd2: begin sel = SEL_TOP;   first = wh;            n = wr;       rev = 1'b0; dv = hh; end
      3'd3: begin sel = SEL_RIGHT; first = '0;            n = hh;       rev = 1'b1; dv = wr; end
      3'd4: begin sel = SEL_BOT;   first = '0;            n = wh;       rev = 1'b1; dv = hr; end
      3'd5: begin sel = SEL_LEFT;  first = hh;            n = hr;       rev = 1'b0; dv = wh; end
      3'd6: begin sel = SEL_BOT;   first = wh;            n = wr;       rev = 1'b0; dv = hr; end
      3'd7: begin sel = SEL_RIGHT; first = hh;            n = hr;       rev = 1'b0; dv = wr; end
      default: begin sel = SEL_TOP; first = '0; n = wh; rev = 1'b1; dv = hh; end
    endcase
  end

  assign half      = n >> 1;
  assign walk_addr = first + j_q;
  // Reversed profiles take the head from the top indexes; the walk always reads upward
  assign is_head   = rev ? (j_q >= n - half) : (j_q < half);
  assign sts_o.entry_last   = (j_q == n - XW'(1));
  assign sts_o.profile_last = (p_q == 3'd7);

  // Memories
  logic [SUM_W-1:0] top_rd, bot_rd, left_rd, right_rd;
  logic [XW-1:0]    col_addr;
  logic [YW-1:0]    row_addr;
  logic             col_re;

  assign col_addr = cmd_i.walk_rd ? walk_addr : x_q;
  assign row_addr = cmd_i.walk_rd ? walk_addr : y_q;
  assign col_re   = cmd_i.pix_rd | cmd_i.walk_rd;
  assign col_rd   = top_half ? top_rd : bot_rd;
  assign col_new  = first_row ? gray_ext : col_rd + gray_ext;

  qpp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_top (
    .clk_i, .addr_i(col_addr), .we_i(cmd_i.pix_wr & top_half),
    .wdata_i(col_new), .re_i(col_re), .rdata_o(top_rd));
  qpp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_bot (
    .clk_i, .addr_i(col_addr), .we_i(cmd_i.pix_wr & ~top_half),
    .wdata_i(col_new), .re_i(col_re), .rdata_o(bot_rd));
  qpp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_HEIGHT)) u_left (
    .clk_i, .addr_i(row_addr), .we_i(cmd_i.pix_wr & row_end),
    .wdata_i(lacc_new), .re_i(cmd_i.walk_rd), .rdata_o(left_rd));
  qpp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_HEIGHT)) u_right (
    .clk_i, .addr_i(row_addr), .we_i(cmd_i.pix_wr & row_end),
    .wdata_i(racc_new), .re_i(cmd_i.walk_rd), .rdata_o(right_rd));

  logic [SUM_W-1:0] walk_rd;
  always_comb begin
    unique case (sel)
      SEL_TOP:   walk_rd = top_rd;
      SEL_BOT:   walk_rd = bot_rd;
      SEL_LEFT:  walk_rd = left_rd;
      SEL_RIGHT: walk_rd = right_rd;
      default:   walk_rd = top_rd;
    endcase
  end

  // Restoring divider: quotient fits 8 bits, so start from the top 9 bits
  logic [XW-1:0]    rem_q;
  logic [7:0]       dlo_q, quo_q;
  logic [2:0]       dcnt_q;
  logic [XW:0]      trial, trial_sub;
  logic             qbit;

  assign trial     = {rem_q, dlo_q[7]};
  assign qbit      = (trial >= {1'b0, dv});
  assign trial_sub = trial - {1'b0, dv};
  assign sts_o.div_last = (dcnt_q == 3'd7);

  logic [SUM_W-1:0]  total_q, head_q;
  logic [PIX_W-1:0]  peak_q;
  logic [7:0]        mask_q;
  logic [PROD_W-1:0] prod_q, rhs;
  assign rhs = PROD_W'(half) * PROD_W'(total_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_rd) gray_q <= qpp_gray(red_i, green_i, blue_i);
    if (cmd_i.div_load) begin
      rem_q  <= XW'(walk_rd[SUM_W-1:8]);
      dlo_q  <= walk_rd[7:0];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= qbit ? trial_sub[XW-1:0] : trial[XW-1:0];
      dlo_q  <= {dlo_q[6:0], 1'b0};
      quo_q  <= {quo_q[6:0], qbit};
    end
    if (cmd_i.mul) prod_q <= PROD_W'(n) * PROD_W'(head_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q             <= '0;
      y_q             <= '0;
      lacc_q          <= '0;
      racc_q          <= '0;
      p_q             <= '0;
      j_q             <= '0;
      dcnt_q          <= '0;
      total_q         <= '0;
      head_q          <= '0;
      peak_q          <= '0;
      mask_q          <= '0;
      out_valid_o     <= 1'b0;
      frame_good_o    <= 1'b0;
      negative_mask_o <= '0;
      peak_value_o    <= '0;
    end else begin
      if (cfg_clear_i) begin
        x_q    <= '0;
        y_q    <= '0;
        lacc_q <= '0;
        racc_q <= '0;
      end else if (cmd_i.pix_wr) begin
        if (row_end) begin
          x_q    <= '0;
          y_q    <= sts_o.frame_end ? '0 : y_q + YW'(1);
          lacc_q <= '0;
          racc_q <= '0;
        end else begin
          x_q    <= x_q + XW'(1);
          lacc_q <= lacc_new;
          racc_q <= racc_new;
        end
      end
      if (cmd_i.div_load)      dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + 3'd1;
      if (cmd_i.walk_start) begin
        p_q     <= '0;
        j_q     <= '0;
        total_q <= '0;
        head_q  <= '0;
        peak_q  <= '0;
        mask_q  <= '0;
      end else if (cmd_i.acc) begin
        total_q <= total_q + {{(SUM_W-8){1'b0}}, quo_q};
        if (is_head) head_q <= head_q + {{(SUM_W-8){1'b0}}, quo_q};
        if (quo_q > peak_q) peak_q <= quo_q;
        j_q     <= j_q + XW'(1);
      end else if (cmd_i.cmp) begin
        mask_q[p_q] <= (prod_q < rhs);
        p_q         <= p_q + 3'd1;
        j_q         <= '0;
        total_q     <= '0;
        head_q      <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_o     <= 1'b1;
        frame_good_o    <= (mask_q == '0) && (peak_q >= thr_i);
        negative_mask_o <= mask_q;
        peak_value_o    <= peak_q;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign sts_o.out_busy = out_valid_o;

  a_x_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, x_q} < w_eff)) else $error("column position beyond frame width");
  a_head_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= total_q)) else $error("head sum exceeds profile total");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_o) else $error("result not presented after load");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_o) else $error("result overwritten while pending");
endmodule
